### hdl/cgl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_pkg
// Types, constants and saturation helpers for the Ginzburg-Landau RK stage
// update datapath.
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned WideW    = 48;
  localparam int unsigned DtW      = 31;
  localparam int unsigned GridW    = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic signed [WideW-1:0]  Max48 = {1'b0, {(WideW-1){1'b1}}};
  localparam logic signed [WideW-1:0]  Min48 = {1'b1, {(WideW-1){1'b0}}};
  localparam logic signed [FieldW-1:0] Max32 = {1'b0, {(FieldW-1){1'b1}}};
  localparam logic signed [FieldW-1:0] Min32 = {1'b1, {(FieldW-1){1'b0}}};

  localparam logic [WideW-1:0] KQuarter = WideW'(64'd1 << (FracBits - 2));
  localparam logic [WideW-1:0] KThird   = WideW'(((64'd1 << FracBits) + 64'd1) / 64'd3);
  localparam logic [WideW-1:0] KHalf    = WideW'(64'd1 << (FracBits - 1));
  localparam logic [WideW-1:0] KFull    = WideW'(64'd1 << FracBits);

  localparam logic [DtW-1:0]    StepDtRst   = '0;
  localparam logic [FieldW-1:0] DiffReRst   = FieldW'(64'd1 << (FracBits - 12));
  localparam logic [FieldW-1:0] DiffImRst   = '0;
  localparam logic [FieldW-1:0] CubicC3Rst  = '0;
  localparam logic [GridW-1:0]  GridLog2Rst = GridW'(7);

  typedef enum logic [1:0] {
    STG_QUARTER,
    STG_THIRD,
    STG_HALF,
    STG_FULL
  } stage_e;

  typedef enum logic [2:0] {
    REG_STEP_DT,
    REG_DIFF_RE,
    REG_DIFF_IM,
    REG_CUBIC_C3,
    REG_GRID_LOG2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [FieldW-1:0] start_re;
    logic signed [FieldW-1:0] start_im;
    logic signed [FieldW-1:0] stage_re;
    logic signed [FieldW-1:0] stage_im;
    logic signed [WideW-1:0]  lap_re;
    logic signed [WideW-1:0]  lap_im;
    logic [1:0]               stage_sel;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] next_re;
    logic signed [FieldW-1:0] next_im;
    logic                     saturated;
  } out_item_t;

  function automatic logic signed [WideW-1:0] sx_field(logic signed [FieldW-1:0] x);
    return {{(WideW-FieldW){x[FieldW-1]}}, x};
  endfunction

  function automatic logic signed [WideW:0] add_w(logic signed [WideW-1:0] a,
                                                   logic signed [WideW-1:0] b);
    return $signed({a[WideW-1], a}) + $signed({b[WideW-1], b});
  endfunction

  function automatic logic signed [WideW:0] sub_w(logic signed [WideW-1:0] a,
                                                   logic signed [WideW-1:0] b);
    return $signed({a[WideW-1], a}) - $signed({b[WideW-1], b});
  endfunction

  function automatic logic ovf_w(logic signed [WideW:0] v);
    return v[WideW] ^ v[WideW-1];
  endfunction

  function automatic logic signed [WideW-1:0] sat_w(logic signed [WideW:0] v);
    logic signed [WideW-1:0] r;
    if (ovf_w(v)) begin
      r = v[WideW] ? Min48 : Max48;
    end else begin
      r = v[WideW-1:0];
    end
    return r;
  endfunction

  function automatic logic ovf_n(logic signed [WideW:0] v);
    return v[WideW:FieldW-1] != {(WideW-FieldW+2){v[WideW]}};
  endfunction

  function automatic logic signed [FieldW-1:0] sat_n(logic signed [WideW:0] v);
    logic signed [FieldW-1:0] r;
    if (ovf_n(v)) begin
      r = v[WideW] ? Min32 : Max32;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

  function automatic logic [WideW-1:0] stage_coef(logic [1:0] sel);
    logic [WideW-1:0] k;
    unique case (stage_e'(sel))
      STG_QUARTER: k = KQuarter;
      STG_THIRD:   k = KThird;
      STG_HALF:    k = KHalf;
      STG_FULL:    k = KFull;
      default:     k = KFull;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### hdl/cgl_mulq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_mulq
// Four-stage fixed-point multiplier: sign and magnitude, 24x24 partial
// products, rounded sum, then shift, saturation and sign restore.
// ----------------------------------------------------------------------------
module cgl_mulq (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [cgl_pkg::WideW-1:0]      a_i,
  input  logic signed [cgl_pkg::WideW-1:0]      b_i,
  output logic signed [cgl_pkg::WideW-1:0]      p_o,
  output logic                                  ovf_o
);
  import cgl_pkg::*;

  localparam int unsigned HalfW = WideW / 2;
  localparam int unsigned ProdW = 2 * WideW;
  localparam int unsigned MagW  = ProdW - FracBits;

  logic [WideW-1:0]        ua_q, ub_q;
  logic                    neg1_q, neg2_q, neg3_q;
  logic [WideW-1:0]        pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [ProdW-1:0]        sum_d, sum_q;
  logic [MagW-1:0]         mag_w;
  logic                    sat_w;
  logic [WideW-2:0]        mag_c;
  logic signed [WideW-1:0] p_q;
  logic                    ovf_q;

  always_comb begin
    sum_d = ProdW'(pp_ll_q)
          + (ProdW'(pp_lh_q) << HalfW)
          + (ProdW'(pp_hl_q) << HalfW)
          + (ProdW'(pp_hh_q) << WideW)
          + (ProdW'(1) << (FracBits - 1));
    mag_w = sum_q[ProdW-1:FracBits];
    sat_w = |mag_w[MagW-1:WideW-1];
    mag_c = sat_w ? {(WideW-1){1'b1}} : mag_w[WideW-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q    <= a_i[WideW-1] ? $unsigned(-a_i) : $unsigned(a_i);
      ub_q    <= b_i[WideW-1] ? $unsigned(-b_i) : $unsigned(b_i);
      neg1_q  <= a_i[WideW-1] ^ b_i[WideW-1];
      pp_ll_q <= ua_q[HalfW-1:0] * ub_q[HalfW-1:0];
      pp_lh_q <= ua_q[HalfW-1:0] * ub_q[WideW-1:HalfW];
      pp_hl_q <= ua_q[WideW-1:HalfW] * ub_q[HalfW-1:0];
      pp_hh_q <= ua_q[WideW-1:HalfW] * ub_q[WideW-1:HalfW];
      neg2_q  <= neg1_q;
      sum_q   <= sum_d;
      neg3_q  <= neg2_q;
      p_q     <= neg3_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      ovf_q   <= sat_w;
    end
  end

  assign p_o   = p_q;
  assign ovf_o = ovf_q;

endmodule
`default_nettype wire

### hdl/cgl_dly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_dly
// Enabled delay line that carries side data alongside the arithmetic
// pipeline.
// ----------------------------------------------------------------------------
module cgl_dly #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule
`default_nettype wire

### hdl/cgl_rk_stage_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_rk_stage_update
// Pointwise low-storage RK4 stage update for the complex Ginzburg-Landau
// equation in fixed point.
//
// Each input transaction carries one grid point (step-start value, current
// stage value, unnormalized Laplacian and stage number); each output
// transaction returns the saturated new stage value and a clip flag.
// Both channels use valid/ready. The user must write coefficients, time step
// and grid size through the APB port only while no point is in flight; the
// block itself does not enforce this. One point is accepted every cycle
// unless the pipeline is held; the rate is set by the four-stage multipliers,
// all fully pipelined. Reset clears the pipeline valid bits and loads the
// register defaults. When the receiver stalls with the output register full,
// the whole pipeline holds, except that an empty last stage still lets the
// pipeline advance and close up bubbles.
// ----------------------------------------------------------------------------
module cgl_rk_stage_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cgl_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cgl_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cgl_pkg::AddrW-1:0]  paddr,
  input  logic [cgl_pkg::DataW-1:0]  pwdata,
  output logic [cgl_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import cgl_pkg::*;

  localparam int unsigned NumStg = 15;
  localparam int unsigned PairW  = 2 * FieldW;
  localparam int unsigned ShW    = GridW + 1;

  logic [DtW-1:0]           step_dt_q;
  logic signed [FieldW-1:0] diff_re_q, diff_im_q, cubic_c3_q;
  logic [GridW-1:0]         grid_log2_q;
  logic                     cfg_we;
  cfg_reg_e                 cfg_idx;

  logic                     adv, out_ld;
  logic [NumStg-1:0]        vld_q;
  logic                     out_valid_q;
  out_item_t                out_data_q;
  in_item_t                 in_q;

  logic [ShW-1:0]           shamt;
  logic [WideW:0]           rnd;
  logic signed [WideW:0]    lre_sum, lim_sum, lre_sh, lim_sh;
  logic signed [WideW-1:0]  lr_q, li_q;

  logic signed [WideW-1:0]  p_crr, p_cii, p_c3i, p_c3r, p_kdt;
  logic                     f_crr, f_cii, f_c3i, f_c3r, f_kdt;
  logic signed [WideW-1:0]  p_rr, p_ii, p_ri, p_ir;
  logic                     f_rr, f_ii, f_ri, f_ir;
  logic signed [WideW-1:0]  p_mnr, p_mni, p_outr, p_outi;
  logic                     f_mnr, f_mni, f_outr, f_outi;

  logic [PairW-1:0]         c5, c7, a15;
  logic signed [FieldW-1:0] c5r, c5i, c7r, c7i, a15r, a15i;
  logic [WideW-1:0]         kdt11;
  logic [2*WideW:0]         t10;
  logic                     fl10, fl15;
  logic signed [WideW-1:0]  tr10, ti10;

  logic signed [WideW:0]    mag_s, nr_s, ni_s, dr_s, di_s, tr_s, ti_s, fr_s, fi_s;
  logic signed [WideW:0]    or_s, oi_s;
  logic signed [WideW-1:0]  mag_q, nr_q, ni_q, dr_q, di_q, tr_q, ti_q, fr_q, fi_q;
  logic                     fl6_q, fl7_q, fl8_q, fl11_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_dt_q   <= StepDtRst;
      diff_re_q   <= DiffReRst;
      diff_im_q   <= DiffImRst;
      cubic_c3_q  <= CubicC3Rst;
      grid_log2_q <= GridLog2Rst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEP_DT:   step_dt_q   <= pwdata[DtW-1:0];
        REG_DIFF_RE:   diff_re_q   <= pwdata[FieldW-1:0];
        REG_DIFF_IM:   diff_im_q   <= pwdata[FieldW-1:0];
        REG_CUBIC_C3:  cubic_c3_q  <= pwdata[FieldW-1:0];
        REG_GRID_LOG2: grid_log2_q <= pwdata[GridW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP_DT:   prdata = DataW'(step_dt_q);
      REG_DIFF_RE:   prdata = DataW'(diff_re_q);
      REG_DIFF_IM:   prdata = DataW'(diff_im_q);
      REG_CUBIC_C3:  prdata = DataW'(cubic_c3_q);
      REG_GRID_LOG2: prdata = DataW'(grid_log2_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline control.
  assign adv        = out_ready_i || !out_valid_q || !vld_q[NumStg-1];
  assign out_ld     = adv && vld_q[NumStg-1];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NumStg-2:0], in_valid_i};
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Laplacian normalization, rounding half up.
  always_comb begin
    shamt   = {grid_log2_q, 1'b0};
    rnd     = ((WideW+1)'(1) << shamt) >> 1;
    lre_sum = $signed({in_q.lap_re[WideW-1], in_q.lap_re}) + $signed(rnd);
    lim_sum = $signed({in_q.lap_im[WideW-1], in_q.lap_im}) + $signed(rnd);
    lre_sh  = lre_sum >>> shamt;
    lim_sh  = lim_sum >>> shamt;
  end

  // Product stages.
  cgl_mulq u_m_crr (.clk_i, .en_i(adv), .a_i(sx_field(in_q.stage_re)),
                    .b_i(sx_field(in_q.stage_re)), .p_o(p_crr), .ovf_o(f_crr));
  cgl_mulq u_m_cii (.clk_i, .en_i(adv), .a_i(sx_field(in_q.stage_im)),
                    .b_i(sx_field(in_q.stage_im)), .p_o(p_cii), .ovf_o(f_cii));
  cgl_mulq u_m_c3i (.clk_i, .en_i(adv), .a_i(sx_field(cubic_c3_q)),
                    .b_i(sx_field(in_q.stage_im)), .p_o(p_c3i), .ovf_o(f_c3i));
  cgl_mulq u_m_c3r (.clk_i, .en_i(adv), .a_i(sx_field(cubic_c3_q)),
                    .b_i(sx_field(in_q.stage_re)), .p_o(p_c3r), .ovf_o(f_c3r));
  cgl_mulq u_m_kdt (.clk_i, .en_i(adv), .a_i($signed(stage_coef(in_q.stage_sel))),
                    .b_i($signed({{(WideW-DtW){1'b0}}, step_dt_q})),
                    .p_o(p_kdt), .ovf_o(f_kdt));

  cgl_mulq u_m_rr (.clk_i, .en_i(adv), .a_i(sx_field(diff_re_q)), .b_i(lr_q),
                   .p_o(p_rr), .ovf_o(f_rr));
  cgl_mulq u_m_ii (.clk_i, .en_i(adv), .a_i(sx_field(diff_im_q)), .b_i(li_q),
                   .p_o(p_ii), .ovf_o(f_ii));
  cgl_mulq u_m_ri (.clk_i, .en_i(adv), .a_i(sx_field(diff_re_q)), .b_i(li_q),
                   .p_o(p_ri), .ovf_o(f_ri));
  cgl_mulq u_m_ir (.clk_i, .en_i(adv), .a_i(sx_field(diff_im_q)), .b_i(lr_q),
                   .p_o(p_ir), .ovf_o(f_ir));

  cgl_mulq u_m_mnr (.clk_i, .en_i(adv), .a_i(mag_q), .b_i(nr_q),
                    .p_o(p_mnr), .ovf_o(f_mnr));
  cgl_mulq u_m_mni (.clk_i, .en_i(adv), .a_i(mag_q), .b_i(ni_q),
                    .p_o(p_mni), .ovf_o(f_mni));

  cgl_mulq u_m_outr (.clk_i, .en_i(adv), .a_i($signed(kdt11)), .b_i(fr_q),
                     .p_o(p_outr), .ovf_o(f_outr));
  cgl_mulq u_m_outi (.clk_i, .en_i(adv), .a_i($signed(kdt11)), .b_i(fi_q),
                     .p_o(p_outi), .ovf_o(f_outi));

  // Side data delays.
  cgl_dly #(.Width(PairW), .Depth(4)) u_dly_c5 (
    .clk_i, .en_i(adv), .d_i({in_q.stage_re, in_q.stage_im}), .q_o(c5));
  cgl_dly #(.Width(PairW), .Depth(2)) u_dly_c7 (
    .clk_i, .en_i(adv), .d_i(c5), .q_o(c7));
  cgl_dly #(.Width(PairW), .Depth(14)) u_dly_a (
    .clk_i, .en_i(adv), .d_i({in_q.start_re, in_q.start_im}), .q_o(a15));
  cgl_dly #(.Width(WideW), .Depth(6)) u_dly_k (
    .clk_i, .en_i(adv), .d_i(p_kdt), .q_o(kdt11));
  cgl_dly #(.Width(2*WideW+1), .Depth(2)) u_dly_t (
    .clk_i, .en_i(adv), .d_i({fl8_q, tr_q, ti_q}), .q_o(t10));
  cgl_dly #(.Width(1), .Depth(4)) u_dly_f (
    .clk_i, .en_i(adv), .d_i(fl11_q), .q_o(fl15));

  assign c5r  = c5[PairW-1:FieldW];
  assign c5i  = c5[FieldW-1:0];
  assign c7r  = c7[PairW-1:FieldW];
  assign c7i  = c7[FieldW-1:0];
  assign a15r = a15[PairW-1:FieldW];
  assign a15i = a15[FieldW-1:0];
  assign fl10 = t10[2*WideW];
  assign tr10 = t10[2*WideW-1:WideW];
  assign ti10 = t10[WideW-1:0];

  // Sums between the product stages.
  always_comb begin
    mag_s = add_w(p_crr, p_cii);
    nr_s  = add_w(sx_field(c5r), p_c3i);
    ni_s  = sub_w(sx_field(c5i), p_c3r);
    dr_s  = sub_w(p_rr, p_ii);
    di_s  = add_w(p_ri, p_ir);
    tr_s  = add_w(sx_field(c7r), dr_q);
    ti_s  = add_w(sx_field(c7i), di_q);
    fr_s  = sub_w(tr10, p_mnr);
    fi_s  = sub_w(ti10, p_mni);
    or_s  = add_w(sx_field(a15r), p_outr);
    oi_s  = add_w(sx_field(a15i), p_outi);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q   <= in_data_i;
      lr_q   <= lre_sh[WideW-1:0];
      li_q   <= lim_sh[WideW-1:0];
      mag_q  <= sat_w(mag_s);
      nr_q   <= sat_w(nr_s);
      ni_q   <= sat_w(ni_s);
      fl6_q  <= f_crr | f_cii | f_c3i | f_c3r | f_kdt
              | ovf_w(mag_s) | ovf_w(nr_s) | ovf_w(ni_s);
      dr_q   <= sat_w(dr_s);
      di_q   <= sat_w(di_s);
      fl7_q  <= fl6_q | f_rr | f_ii | f_ri | f_ir | ovf_w(dr_s) | ovf_w(di_s);
      tr_q   <= sat_w(tr_s);
      ti_q   <= sat_w(ti_s);
      fl8_q  <= fl7_q | ovf_w(tr_s) | ovf_w(ti_s);
      fr_q   <= sat_w(fr_s);
      fi_q   <= sat_w(fi_s);
      fl11_q <= fl10 | f_mnr | f_mni | ovf_w(fr_s) | ovf_w(fi_s);
    end
    if (out_ld) begin
      out_data_q.next_re   <= sat_n(or_s);
      out_data_q.next_im   <= sat_n(oi_s);
      out_data_q.saturated <= fl15 | f_outr | f_outi | ovf_n(or_s) | ovf_n(oi_s);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("Input stalled while the output register is empty.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("Accepted transaction did not enter the first stage.");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> !vld_q[0])
    else $error("First stage became valid without an input transaction.");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[NumStg-1]))
    else $error("Output became valid without an item in the last stage.");

endmodule
`default_nettype wire

### tb/sv/cgl_stage_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgl_stage_check
// Watches the point and result channels and the register port of the RK stage
// update block. It tracks the register values, computes the new stage value for
// every accepted point in a bit-exact fixed-point model, and compares each
// accepted result transaction in order, field by field.
// ----------------------------------------------------------------------------
module cgl_stage_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  cgl_pkg::in_item_t          in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  cgl_pkg::out_item_t         out_data_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [cgl_pkg::AddrW-1:0]  paddr,
  input  logic [cgl_pkg::DataW-1:0]  pwdata,
  output int                         err_cnt_o,
  output int                         pend_cnt_o,
  output int                         seen_cnt_o,
  output int                         clip_cnt_o
);
  import cgl_pkg::*;

  localparam int     F    = FracBits;
  localparam longint Hi48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint Lo48 = -64'sh8000_0000_0000;
  localparam longint Hi32 = 64'sd2147483647;
  localparam longint Lo32 = -64'sd2147483648;

  longint    dt_q;
  longint    dre_q;
  longint    dim_q;
  longint    c3_q;
  int        glog_q;
  out_item_t next_q[$];

  function automatic longint clamp48(longint v, inout bit clip);
    longint r;
    r = v;
    if (v > Hi48) begin
      clip = 1'b1;
      r = Hi48;
    end else if (v < Lo48) begin
      clip = 1'b1;
      r = Lo48;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v, inout bit clip);
    logic [31:0] r;
    r = v[31:0];
    if (v > Hi32) begin
      clip = 1'b1;
      r = Max32;
    end else if (v < Lo32) begin
      clip = 1'b1;
      r = Min32;
    end
    return r;
  endfunction

  // Exact product, rounded half away from zero, clipped to the 48-bit range.
  function automatic longint qmul(longint a, longint b, inout bit clip);
    longint      ta;
    longint      tb;
    longint      m;
    logic [95:0] prod;
    logic [95:0] rnd;
    ta = (a < 0) ? -a : a;
    tb = (b < 0) ? -b : b;
    prod = {48'd0, ta[47:0]} * {48'd0, tb[47:0]};
    rnd = (prod + (96'd1 << (F - 1))) >> F;
    if (rnd[95:47] != '0) begin
      clip = 1'b1;
      m = Hi48;
    end else begin
      m = rnd[47:0];
    end
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Division by N squared, rounding half toward plus infinity.
  function automatic longint norm_shift(longint x, int s);
    longint r;
    r = x;
    if (s > 0) begin
      r = (x + (64'sd1 <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  function automatic out_item_t predict_stage(in_item_t p);
    bit        clip;
    longint    ar, ai, cr, ci, lr, li;
    longint    t1, t2, dr, di, mag, nr, ni, fr, fi, kc, kdt;
    out_item_t o;
    clip = 1'b0;
    ar = $signed(p.start_re);
    ai = $signed(p.start_im);
    cr = $signed(p.stage_re);
    ci = $signed(p.stage_im);
    lr = norm_shift($signed(p.lap_re), 2 * glog_q);
    li = norm_shift($signed(p.lap_im), 2 * glog_q);

    t1 = qmul(dre_q, lr, clip);
    t2 = qmul(dim_q, li, clip);
    dr = clamp48(t1 - t2, clip);
    t1 = qmul(dre_q, li, clip);
    t2 = qmul(dim_q, lr, clip);
    di = clamp48(t1 + t2, clip);
    t1 = qmul(cr, cr, clip);
    t2 = qmul(ci, ci, clip);
    mag = clamp48(t1 + t2, clip);
    t1 = qmul(c3_q, ci, clip);
    nr = clamp48(cr + t1, clip);
    t1 = qmul(c3_q, cr, clip);
    ni = clamp48(ci - t1, clip);
    t1 = clamp48(cr + dr, clip);
    t2 = qmul(mag, nr, clip);
    fr = clamp48(t1 - t2, clip);
    t1 = clamp48(ci + di, clip);
    t2 = qmul(mag, ni, clip);
    fi = clamp48(t1 - t2, clip);

    case (stage_e'(p.stage_sel))
      STG_QUARTER: kc = 64'sd1 <<< (F - 2);
      STG_THIRD:   kc = ((64'sd1 <<< F) + 1) / 3;
      STG_HALF:    kc = 64'sd1 <<< (F - 1);
      default:     kc = 64'sd1 <<< F;
    endcase
    kdt = qmul(kc, dt_q, clip);

    t1 = qmul(kdt, fr, clip);
    o.next_re = clamp32(ar + t1, clip);
    t2 = qmul(kdt, fi, clip);
    o.next_im = clamp32(ai + t2, clip);
    o.saturated = clip;
    return o;
  endfunction

  task automatic report(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
    err_cnt_o++;
    $display("%0t: %s mismatch, expected %h got %h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      next_q.delete();
      dt_q       = StepDtRst;
      dre_q      = $signed(DiffReRst);
      dim_q      = $signed(DiffImRst);
      c3_q       = $signed(CubicC3Rst);
      glog_q     = GridLog2Rst;
      err_cnt_o  = 0;
      pend_cnt_o = 0;
      seen_cnt_o = 0;
      clip_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_cnt_o++;
        if (out_data_i.saturated) begin
          clip_cnt_o++;
        end
        if (next_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result transaction with none expected, got re %h im %h sat %b",
                   $time, out_data_i.next_re, out_data_i.next_im, out_data_i.saturated);
        end else begin
          want = next_q.pop_front();
          if (out_data_i.next_re !== want.next_re) begin
            report("next_re", want.next_re, out_data_i.next_re);
          end
          if (out_data_i.next_im !== want.next_im) begin
            report("next_im", want.next_im, out_data_i.next_im);
          end
          if (out_data_i.saturated !== want.saturated) begin
            report("saturated", 32'(want.saturated), 32'(out_data_i.saturated));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_q.push_back(predict_stage(in_data_i));
      end
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[AddrW-1:2]))
          REG_STEP_DT:   dt_q   = pwdata[DtW-1:0];
          REG_DIFF_RE:   dre_q  = $signed(pwdata);
          REG_DIFF_IM:   dim_q  = $signed(pwdata);
          REG_CUBIC_C3:  c3_q   = $signed(pwdata);
          REG_GRID_LOG2: glog_q = pwdata[GridW-1:0];
          default: ;
        endcase
      end
      pend_cnt_o = next_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the Ginzburg-Landau RK stage update block. It programs the
// registers over APB in several settings, extremes included, and streams
// directed and random grid points with random gaps and receiver stalls. The
// checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
  import cgl_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic signed [31:0] One  = 32'sh0100_0000;
  localparam logic signed [31:0] Half = 32'sh0080_0000;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [AddrW-1:0]   paddr     = '0;
  logic [DataW-1:0]   pwdata    = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  int err_cnt, pend_cnt, seen_cnt, clip_cnt;
  int cycles     = 0;
  int tx_calm    = 0;
  int rx_calm    = 0;
  int n_directed = 0;
  int n_random   = 0;
  int n_settings = 0;

  cgl_rk_stage_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  cgl_stage_check chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt),
    .seen_cnt_o  (seen_cnt),
    .clip_cnt_o  (clip_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pend_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_wait(inout int calm);
    int w;
    if (calm > 0) begin
      calm = calm - 1;
      w = 0;
    end else begin
      if ($urandom_range(0, 31) == 0) begin
        calm = $urandom_range(8, 40);
      end
      w = $urandom_range(0, 14);
    end
    return w;
  endfunction

  function automatic longint spread(int w, int lo);
    longint v;
    v = {$urandom, $urandom};
    v = (v <<< (64 - w)) >>> (64 - w);
    if (lo == 0 && $urandom_range(0, 15) == 0) begin
      v = $urandom_range(0, 1) ? ((64'sd1 <<< (w - 1)) - 1) : -(64'sd1 <<< (w - 1));
    end else begin
      v = v >>> $urandom_range(lo, w - 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_coef();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0:       c = Min32;
      1:       c = Max32;
      2:       c = '0;
      3, 4:    c = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: c = $urandom;
    endcase
    return c;
  endfunction

  function automatic in_item_t pt(logic [31:0] ar, logic [31:0] ai, logic [31:0] cr,
                                  logic [31:0] ci, logic [47:0] lr, logic [47:0] li,
                                  stage_e s);
    in_item_t p;
    p.start_re  = ar;
    p.start_im  = ai;
    p.stage_re  = cr;
    p.stage_im  = ci;
    p.lap_re    = lr;
    p.lap_im    = li;
    p.stage_sel = s;
    return p;
  endfunction

  function automatic in_item_t rand_point(bit physical);
    in_item_t p;
    int       sh;
    sh = physical ? 6 : 0;
    p.start_re  = 32'(spread(32, sh));
    p.start_im  = 32'(spread(32, sh));
    p.stage_re  = 32'(spread(32, sh));
    p.stage_im  = 32'(spread(32, sh));
    p.lap_re    = 48'(spread(48, physical ? 8 : 0));
    p.lap_im    = 48'(spread(48, physical ? 8 : 0));
    p.stage_sel = 2'($urandom_range(0, 3));
    return p;
  endfunction

  task automatic send_point(input in_item_t p);
    int   gap;
    logic took;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pend_cnt != 0);
    @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_reg_e r, input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The unused upper bits of the narrow registers carry random values.
  task automatic set_config(input logic [30:0] dt, input logic [31:0] dre,
                            input logic [31:0] dim, input logic [31:0] c3,
                            input logic [3:0] g);
    drain();
    repeat (4) @(posedge clk_i);
    reg_write(REG_STEP_DT, {1'($urandom), dt});
    reg_write(REG_DIFF_RE, dre);
    reg_write(REG_DIFF_IM, dim);
    reg_write(REG_CUBIC_C3, c3);
    reg_write(REG_GRID_LOG2, {28'($urandom), g});
    n_settings++;
  endtask

  task automatic send_directed(input in_item_t p);
    send_point(p);
    n_directed++;
  endtask

  initial begin
    int          stall;
    logic        took;
    @(posedge clk_i);
    forever begin
      stall = pick_wait(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  initial begin
    logic [30:0] dt;
    logic [3:0]  g;
    int          pause_at;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_directed(pt('0, '0, '0, '0, '0, '0, STG_QUARTER));
    send_directed(pt(Max32, Min32, One, -One, '0, '0, STG_THIRD));
    send_directed(pt(Min32, Max32, Max32, Max32, Max48, Min48, STG_HALF));
    send_directed(pt(One, One, Min32, Min32, Min48, Max48, STG_FULL));

    set_config(31'd167772, One, Half, -32'sh00C0_0000, 4'd6);
    send_directed(pt(Half, '0, 32'sh00CC_CCCD, -32'sh004C_CCCD,
                     48'sh0000_3000_0000, -48'sh0000_1000_0000, STG_QUARTER));
    send_directed(pt(Half, '0, 32'sh00CC_CCCD, -32'sh004C_CCCD,
                     48'sh0000_3000_0000, -48'sh0000_1000_0000, STG_THIRD));
    send_directed(pt(Half, '0, 32'sh00CC_CCCD, -32'sh004C_CCCD,
                     48'sh0000_3000_0000, -48'sh0000_1000_0000, STG_HALF));
    send_directed(pt(Half, '0, 32'sh00CC_CCCD, -32'sh004C_CCCD,
                     48'sh0000_3000_0000, -48'sh0000_1000_0000, STG_FULL));
    send_directed(pt('0, '0, '0, '0, 48'sh800, -48'sh800, STG_FULL));
    send_directed(pt('0, '0, '0, '0, 48'sh1800, -48'sh1801, STG_HALF));
    send_directed(pt(Max32, Min32, One, One, Max48, Min48, STG_FULL));
    send_directed(pt(Min32, Max32, Min32, Max32, '0, '0, STG_THIRD));
    send_directed(pt('0, '0, Max32, Min32, Max48, Max48, STG_QUARTER));

    set_config('1, Max32, Min32, Min32, 4'd0);
    send_directed(pt('0, '0, One, -One, 48'sh0001_0000_0000, '0, STG_QUARTER));
    send_directed(pt(Max32, Max32, Max32, Max32, Max48, Max48, STG_FULL));
    send_directed(pt(Min32, Min32, Min32, Min32, Min48, Min48, STG_THIRD));
    send_directed(pt('0, '0, '0, '0, '0, '0, STG_HALF));

    set_config(31'd1, Min32, Max32, Max32, 4'd15);
    send_directed(pt(Half, -Half, One, One, Min48, Max48, STG_FULL));
    send_directed(pt(-One, One, -Half, Half, 48'sh3FFF_FFFF, -48'sh4000_0000, STG_HALF));
    send_directed(pt('0, '0, '0, '0, 48'sh2000_0000, -48'sh2000_0000, STG_QUARTER));

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       dt = '0;
        1:       dt = '1;
        2:       dt = 31'($urandom_range(0, 32'h0040_0000));
        default: dt = 31'($urandom);
      endcase
      g = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 10));
      set_config(dt, pick_coef(), pick_coef(), pick_coef(), g);
      pause_at = $urandom_range(10, 90);
      for (int i = 0; i < 105; i++) begin
        if (i == pause_at) begin
          drain();
        end
        send_point(rand_point($urandom_range(0, 3) != 0));
        n_random++;
      end
    end

    drain();
    repeat (24) @(posedge clk_i);
    $display("Sent %0d directed and %0d random points over %0d register settings.",
             n_directed, n_random, n_settings);
    $display("Checked %0d result transactions, %0d of them clipped; %0d mismatches.",
             seen_cnt, clip_cnt, err_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
